>>> sv/grid_voxel_step_unit_assert.svh
// Assertion macros shared by the voxel step unit RTL.
`ifndef GRID_VOXEL_STEP_UNIT_ASSERT_SVH
`define GRID_VOXEL_STEP_UNIT_ASSERT_SVH

`ifndef ASSERT_OFF
// Checked outside reset.
`define GVS_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define GVS_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define GVS_ASSERT(lbl, prop, msg)
`define GVS_ASSERT_ALWAYS(lbl, prop, msg)
`endif

`endif

>>> sv/gvs_pkg.sv
// Shared constants and types of the voxel step unit.
package gvs_pkg;

  localparam int GVS_GRID_LIMIT = 64;

  // Quotient bits, one divider stage each.
  localparam int DIV_STAGES = 64;
  // Product, numerator, magnitude, divider, sign fix.
  localparam int AXIS_LAT   = DIV_STAGES + 4;
  // Nearest-face pick, then step and saturate.
  localparam int PICK_LAT   = 2;
  localparam int LATENCY    = AXIS_LAT + PICK_LAT;

  localparam logic [30:0] T_MAX   = 31'h7FFF_FFFF;
  localparam logic [5:0]  NO_CELL = 6'd63;

  localparam logic [30:0] CELL_SIZE_RST  = 31'd65536;
  localparam logic [31:0] GRID_LOW_RST   = 32'd0;
  localparam logic [6:0]  GRID_CELLS_RST = 7'd8;

  // Register indexes (byte address / 4).
  localparam logic [2:0] REG_CELL_SIZE_X = 3'd0;
  localparam logic [2:0] REG_CELL_SIZE_Y = 3'd1;
  localparam logic [2:0] REG_CELL_SIZE_Z = 3'd2;
  localparam logic [2:0] REG_GRID_LOW_X  = 3'd3;
  localparam logic [2:0] REG_GRID_LOW_Y  = 3'd4;
  localparam logic [2:0] REG_GRID_LOW_Z  = 3'd5;
  localparam logic [2:0] REG_GRID_CELLS  = 3'd6;

  // Per-axis face distance and what the pick stage needs of that axis.
  typedef struct packed {
    logic signed [63:0] fdist;
    logic               nz;
    logic               pos;
    logic [5:0]         cidx;
  } gvs_lane_t;

endpackage

>>> sv/gvs_axis.sv
// One axis: exit-face numerator and a pipelined signed 64/32 divider.
module gvs_axis
  import gvs_pkg::*;
#(
  parameter int TAG_W = 8
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                vld_in,
  input  logic [30:0]         t_now,
  input  logic [31:0]         org,
  input  logic [31:0]         dir,
  input  logic [5:0]          cur_cell,
  input  logic [TAG_W-1:0]    tag_in,
  input  logic [30:0]         cell_size,
  input  logic [31:0]         grid_low,
  output logic                vld_out,
  output logic signed [63:0]  face_dist,
  output logic [TAG_W-1:0]    tag_out
);

  // stage 1: products
  logic                s1_vld;
  logic [37:0]         s1_face_prod;
  logic signed [63:0]  s1_tdir;
  logic [31:0]         s1_org;
  logic [31:0]         s1_dir;
  logic [TAG_W-1:0]    s1_tag;
  logic [6:0]          face_cell;

  assign face_cell = dir[31] ? {1'b0, cur_cell} : ({1'b0, cur_cell} + 7'd1);

  always_ff @(posedge clk) begin
    if (rst) s1_vld <= 1'b0;
    else     s1_vld <= vld_in;
  end

  always_ff @(posedge clk) begin
    s1_face_prod <= 38'(face_cell) * 38'(cell_size);
    s1_tdir      <= $signed({33'd0, t_now}) * $signed({{32{dir[31]}}, dir});
    s1_org       <= org;
    s1_dir       <= dir;
    s1_tag       <= tag_in;
  end

  // stage 2: num = face*2^16 - org*2^16 - t*dir
  logic                s2_vld;
  logic signed [63:0]  s2_num;
  logic [31:0]         s2_dir;
  logic [TAG_W-1:0]    s2_tag;
  logic signed [39:0]  face;
  logic signed [63:0]  face_w;
  logic signed [63:0]  org_w;

  assign face   = $signed({2'b00, s1_face_prod}) + $signed({{8{grid_low[31]}}, grid_low});
  assign face_w = {{8{face[39]}}, face, 16'd0};
  assign org_w  = {{16{s1_org[31]}}, s1_org, 16'd0};

  always_ff @(posedge clk) begin
    if (rst) s2_vld <= 1'b0;
    else     s2_vld <= s1_vld;
  end

  always_ff @(posedge clk) begin
    s2_num <= face_w - org_w - s1_tdir;
    s2_dir <= s1_dir;
    s2_tag <= s1_tag;
  end

  // stage 3: magnitudes into the divider
  logic [63:0]       st_nq  [DIV_STAGES+1];
  logic [31:0]       st_d   [DIV_STAGES];
  logic [31:0]       st_rem [1:DIV_STAGES-1];
  logic              st_neg [DIV_STAGES+1];
  logic              st_vld [DIV_STAGES+1];
  logic [TAG_W-1:0]  st_tag [DIV_STAGES+1];

  always_ff @(posedge clk) begin
    if (rst) st_vld[0] <= 1'b0;
    else     st_vld[0] <= s2_vld;
  end

  always_ff @(posedge clk) begin
    st_nq[0]  <= s2_num[63] ? 64'(-s2_num) : 64'(s2_num);
    st_d[0]   <= s2_dir[31] ? (~s2_dir + 32'd1) : s2_dir;
    st_neg[0] <= s2_num[63] ^ s2_dir[31];
    st_tag[0] <= s2_tag;
  end

  // restoring divider, one quotient bit per stage
  for (genvar i = 0; i < DIV_STAGES; i++) begin : g_div
    logic [31:0] rem_in;
    logic [32:0] rem_sh;
    logic [32:0] diff;
    logic        qbit;

    if (i == 0) begin : g_first
      assign rem_in = '0;
    end else begin : g_rest
      assign rem_in = st_rem[i];
    end

    assign rem_sh = {rem_in, st_nq[i][63]};
    assign diff   = rem_sh - {1'b0, st_d[i]};
    assign qbit   = ~diff[32];

    always_ff @(posedge clk) begin
      if (rst) st_vld[i+1] <= 1'b0;
      else     st_vld[i+1] <= st_vld[i];
    end

    always_ff @(posedge clk) begin
      st_nq[i+1]  <= {st_nq[i][62:0], qbit};
      st_neg[i+1] <= st_neg[i];
      st_tag[i+1] <= st_tag[i];
    end

    if (i < DIV_STAGES - 1) begin : g_carry
      always_ff @(posedge clk) begin
        st_rem[i+1] <= qbit ? diff[31:0] : rem_sh[31:0];
        st_d[i+1]   <= st_d[i];
      end
    end
  end

  // sign fix, truncation toward zero
  always_ff @(posedge clk) begin
    if (rst) vld_out <= 1'b0;
    else     vld_out <= st_vld[DIV_STAGES];
  end

  always_ff @(posedge clk) begin
    face_dist <= st_neg[DIV_STAGES] ? -$signed(st_nq[DIV_STAGES])
                                    : $signed(st_nq[DIV_STAGES]);
    tag_out   <= st_tag[DIV_STAGES];
  end

endmodule

>>> sv/gvs_pick.sv
// Nearest exit face, tie stepping, grid check and distance saturation.
module gvs_pick
  import gvs_pkg::*;
#(
  parameter int GRID_LIMIT = GVS_GRID_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        vld_in,
  input  logic [30:0] t_now,
  input  gvs_lane_t   lane_x,
  input  gvs_lane_t   lane_y,
  input  gvs_lane_t   lane_z,
  input  logic [6:0]  grid_cells,
  output logic        done,
  output logic [30:0] t_next,
  output logic [5:0]  next_x,
  output logic [5:0]  next_y,
  output logic [5:0]  next_z,
  output logic        leaves_grid
);

  localparam int LIM_W = $clog2(GRID_LIMIT + 1);
  localparam int CW    = (LIM_W > 7) ? LIM_W : 7;

  // stage 1: minimum over moving axes, ties all step
  logic               m0, m1, m2;
  logic signed [63:0] best;
  logic               p1_vld;
  logic signed [63:0] p1_best;
  logic [2:0]         p1_step;
  logic [2:0]         p1_pos;
  logic [5:0]         p1_cell [3];
  logic               p1_have;
  logic [30:0]        p1_t;

  assign m0 = lane_x.nz && (!lane_y.nz || lane_x.fdist <= lane_y.fdist)
                        && (!lane_z.nz || lane_x.fdist <= lane_z.fdist);
  assign m1 = lane_y.nz && (!lane_x.nz || lane_y.fdist <= lane_x.fdist)
                        && (!lane_z.nz || lane_y.fdist <= lane_z.fdist);
  assign m2 = lane_z.nz && (!lane_x.nz || lane_z.fdist <= lane_x.fdist)
                        && (!lane_y.nz || lane_z.fdist <= lane_y.fdist);

  always_comb begin
    priority if (m0) best = lane_x.fdist;
    else if (m1)     best = lane_y.fdist;
    else             best = lane_z.fdist;
  end

  always_ff @(posedge clk) begin
    if (rst) p1_vld <= 1'b0;
    else     p1_vld <= vld_in;
  end

  always_ff @(posedge clk) begin
    p1_best    <= best;
    p1_step    <= {m2, m1, m0};
    p1_pos     <= {lane_z.pos, lane_y.pos, lane_x.pos};
    p1_cell[0] <= lane_x.cidx;
    p1_cell[1] <= lane_y.cidx;
    p1_cell[2] <= lane_z.cidx;
    p1_have    <= lane_x.nz | lane_y.nz | lane_z.nz;
    p1_t       <= t_now;
  end

  // stage 2: new cell, range check, saturated distance
  logic [CW-1:0]      cells_eff;
  logic [7:0]         nxt [3];
  logic [2:0]         out_of_grid;
  logic               leave;
  logic signed [64:0] t_sum;
  logic [30:0]        t_sat;

  assign cells_eff = (CW'(grid_cells) > CW'(GRID_LIMIT)) ? CW'(GRID_LIMIT) : CW'(grid_cells);

  for (genvar i = 0; i < 3; i++) begin : g_cell
    assign nxt[i] = {2'b00, p1_cell[i]}
                  + (p1_step[i] ? (p1_pos[i] ? 8'd1 : 8'hFF) : 8'd0);
    assign out_of_grid[i] = nxt[i][7] || (CW'(nxt[i][6:0]) >= cells_eff);
  end

  assign leave = !p1_have || (|out_of_grid);
  assign t_sum = $signed({34'd0, p1_t}) + $signed({p1_best[63], p1_best});

  always_comb begin
    priority if (p1_best > $signed({33'd0, T_MAX})) t_sat = T_MAX;
    else if (t_sum < 0)                             t_sat = '0;
    else if (t_sum > $signed({34'd0, T_MAX}))       t_sat = T_MAX;
    else                                            t_sat = t_sum[30:0];
  end

  always_ff @(posedge clk) begin
    if (rst) done <= 1'b0;
    else     done <= p1_vld;
  end

  always_ff @(posedge clk) begin
    leaves_grid <= leave;
    t_next      <= leave ? T_MAX   : t_sat;
    next_x      <= leave ? NO_CELL : nxt[0][5:0];
    next_y      <= leave ? NO_CELL : nxt[1][5:0];
    next_z      <= leave ? NO_CELL : nxt[2][5:0];
  end

endmodule

>>> sv/grid_voxel_step_unit.sv
// Top level of the voxel step unit: register file, three axis lanes, pick stage.
// Each word runs through the three axis lanes (products, numerator, magnitude,
// 64-stage divider, sign fix) and then the pick stage to the result ports.
// Throughput: one word per cycle; busy is low except during reset.
// Reset (rst, synchronous): clears all valid bits and returns the registers to
// their reset values. Results are strobed by done for one cycle each.
`include "grid_voxel_step_unit_assert.svh"
module grid_voxel_step_unit
  import gvs_pkg::*;
#(
  parameter int GRID_LIMIT = GVS_GRID_LIMIT
) (
  input  logic        clk,
  input  logic        rst,
  // command channel
  input  logic        start,
  output logic        busy,
  input  logic [30:0] t_now,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [5:0]  cell_z,
  // results
  output logic        done,
  output logic [30:0] t_next,
  output logic [5:0]  next_x,
  output logic [5:0]  next_y,
  output logic [5:0]  next_z,
  output logic        leaves_grid,
  // register port
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  localparam int TAG_W  = 8;
  localparam int TAG0_W = TAG_W + 31;

  // configuration registers
  logic [30:0] cell_size_x, cell_size_y, cell_size_z;
  logic [31:0] grid_low_x, grid_low_y, grid_low_z;
  logic [6:0]  grid_cells;
  logic        cfg_wr;
  logic [2:0]  reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[4:2];
  assign cfg_wr  = psel & penable & pwrite & pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cell_size_x <= CELL_SIZE_RST;
      cell_size_y <= CELL_SIZE_RST;
      cell_size_z <= CELL_SIZE_RST;
      grid_low_x  <= GRID_LOW_RST;
      grid_low_y  <= GRID_LOW_RST;
      grid_low_z  <= GRID_LOW_RST;
      grid_cells  <= GRID_CELLS_RST;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_CELL_SIZE_X: cell_size_x <= pwdata[30:0];
        REG_CELL_SIZE_Y: cell_size_y <= pwdata[30:0];
        REG_CELL_SIZE_Z: cell_size_z <= pwdata[30:0];
        REG_GRID_LOW_X:  grid_low_x  <= pwdata;
        REG_GRID_LOW_Y:  grid_low_y  <= pwdata;
        REG_GRID_LOW_Z:  grid_low_z  <= pwdata;
        REG_GRID_CELLS:  grid_cells  <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    unique case (reg_idx)
      REG_CELL_SIZE_X: prdata = {1'b0, cell_size_x};
      REG_CELL_SIZE_Y: prdata = {1'b0, cell_size_y};
      REG_CELL_SIZE_Z: prdata = {1'b0, cell_size_z};
      REG_GRID_LOW_X:  prdata = grid_low_x;
      REG_GRID_LOW_Y:  prdata = grid_low_y;
      REG_GRID_LOW_Z:  prdata = grid_low_z;
      REG_GRID_CELLS:  prdata = {25'd0, grid_cells};
      default:         prdata = '0;
    endcase
  end

  // command accept: every cycle outside reset
  logic accept;

  assign busy   = rst;
  assign accept = start & ~busy;

  // axis lanes; lane x also carries t_now
  logic              vld0, vld1, vld2;
  logic signed [63:0] dist0, dist1, dist2;
  logic [TAG0_W-1:0] tag0;
  logic [TAG_W-1:0]  tag1, tag2;
  gvs_lane_t         lane_x, lane_y, lane_z;

  gvs_axis #(.TAG_W(TAG0_W)) u_axis_x (
    .clk, .rst, .vld_in(accept), .t_now, .org(origin_x), .dir(dir_x), .cur_cell(cell_x),
    .tag_in({t_now, cell_x, ~dir_x[31], |dir_x}),
    .cell_size(cell_size_x), .grid_low(grid_low_x),
    .vld_out(vld0), .face_dist(dist0), .tag_out(tag0)
  );

  gvs_axis #(.TAG_W(TAG_W)) u_axis_y (
    .clk, .rst, .vld_in(accept), .t_now, .org(origin_y), .dir(dir_y), .cur_cell(cell_y),
    .tag_in({cell_y, ~dir_y[31], |dir_y}),
    .cell_size(cell_size_y), .grid_low(grid_low_y),
    .vld_out(vld1), .face_dist(dist1), .tag_out(tag1)
  );

  gvs_axis #(.TAG_W(TAG_W)) u_axis_z (
    .clk, .rst, .vld_in(accept), .t_now, .org(origin_z), .dir(dir_z), .cur_cell(cell_z),
    .tag_in({cell_z, ~dir_z[31], |dir_z}),
    .cell_size(cell_size_z), .grid_low(grid_low_z),
    .vld_out(vld2), .face_dist(dist2), .tag_out(tag2)
  );

  assign lane_x = '{fdist: dist0, cidx: tag0[7:2], pos: tag0[1], nz: tag0[0]};
  assign lane_y = '{fdist: dist1, cidx: tag1[7:2], pos: tag1[1], nz: tag1[0]};
  assign lane_z = '{fdist: dist2, cidx: tag2[7:2], pos: tag2[1], nz: tag2[0]};

  gvs_pick #(.GRID_LIMIT(GRID_LIMIT)) u_pick (
    .clk, .rst, .vld_in(vld0), .t_now(tag0[TAG0_W-1:TAG_W]),
    .lane_x, .lane_y, .lane_z, .grid_cells,
    .done, .t_next, .next_x, .next_y, .next_z, .leaves_grid
  );

  // checks
  `GVS_ASSERT(a_lanes_aligned, vld0 == vld1 && vld0 == vld2,
              "axis lanes out of step")
  `GVS_ASSERT(a_latency, done |-> $past(accept, LATENCY),
              "result word without a matching command")
  `GVS_ASSERT(a_cell_in_grid,
              done && !leaves_grid |-> {1'b0, next_x} < grid_cells &&
              {1'b0, next_y} < grid_cells && {1'b0, next_z} < grid_cells,
              "reported cell outside the grid")
  `GVS_ASSERT(a_exit_marker,
              done && leaves_grid |-> t_next == T_MAX && next_x == NO_CELL &&
              next_y == NO_CELL && next_z == NO_CELL,
              "exit word without exit marker")

endmodule

>>> dv/grid_voxel_step_unit_checker.sv
// Result checker for the voxel step unit: predicts each step and compares results.
`timescale 1ns / 1ps
module grid_voxel_step_unit_checker
  import gvs_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  input  logic        busy,
  input  logic [30:0] t_now,
  input  logic [31:0] origin_x,
  input  logic [31:0] origin_y,
  input  logic [31:0] origin_z,
  input  logic [31:0] dir_x,
  input  logic [31:0] dir_y,
  input  logic [31:0] dir_z,
  input  logic [5:0]  cell_x,
  input  logic [5:0]  cell_y,
  input  logic [5:0]  cell_z,
  input  logic        done,
  input  logic [30:0] t_next,
  input  logic [5:0]  next_x,
  input  logic [5:0]  next_y,
  input  logic [5:0]  next_z,
  input  logic        leaves_grid,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [4:0]  paddr,
  input  logic [31:0] pwdata,
  input  logic        pready,
  output int          fail_count,
  output int          pending
);

  typedef struct packed {
    logic [30:0] t;
    logic [5:0]  nx;
    logic [5:0]  ny;
    logic [5:0]  nz;
    logic        leave;
  } step_word_t;

  localparam longint GRID_LIMIT_C = GVS_GRID_LIMIT;
  localparam longint T_MAX_L = 64'h7FFF_FFFF;

  // Shadow of the register file
  logic [30:0] size_q [3];
  logic [31:0] low_q  [3];
  logic [6:0]  cells_q;

  step_word_t step_q[$];

  function automatic step_word_t voxel_step(logic [30:0] tin, logic [31:0] org [3],
                                            logic [31:0] dir [3], logic [5:0] cel [3]);
    step_word_t r;
    longint t, best, face, num, fd, cmax, nxt;
    int s;
    int stp [3];
    bit have, leave;
    t = tin;
    best = 0;
    have = 0;
    leave = 0;
    stp = '{0, 0, 0};
    cmax = (cells_q > GRID_LIMIT_C) ? GRID_LIMIT_C : cells_q;
    for (int i = 0; i < 3; i++) begin
      if (dir[i] == 0) continue;
      s = $signed(dir[i]) > 0 ? 1 : -1;
      face = (s > 0 ? longint'(cel[i]) + 1 : longint'(cel[i])) * longint'(size_q[i])
             + longint'($signed(low_q[i]));
      num = face * 65536 - longint'($signed(org[i])) * 65536
            - t * longint'($signed(dir[i]));
      fd = num / longint'($signed(dir[i]));
      if (!have || fd < best) begin
        stp = '{0, 0, 0};
        stp[i] = s;
        best = fd;
        have = 1;
      end else if (fd == best) begin
        stp[i] = s;
      end
    end
    if (!have) leave = 1;
    for (int i = 0; i < 3; i++) begin
      nxt = longint'(cel[i]) + stp[i];
      if (nxt < 0 || nxt >= cmax) leave = 1;
    end
    if (leave) return '{T_MAX, NO_CELL, NO_CELL, NO_CELL, 1'b1};
    if (best > T_MAX_L) r.t = T_MAX;
    else if (t + best < 0) r.t = '0;
    else if (t + best > T_MAX_L) r.t = T_MAX;
    else r.t = 31'(t + best);
    r.nx = 6'(cel[0] + stp[0]);
    r.ny = 6'(cel[1] + stp[1]);
    r.nz = 6'(cel[2] + stp[2]);
    r.leave = 1'b0;
    return r;
  endfunction

  assign pending = step_q.size();

  always @(posedge clk) begin
    step_word_t exp_w;
    logic [31:0] org [3];
    logic [31:0] dir [3];
    logic [5:0]  cel [3];
    if (rst) begin
      size_q  <= '{CELL_SIZE_RST, CELL_SIZE_RST, CELL_SIZE_RST};
      low_q   <= '{GRID_LOW_RST, GRID_LOW_RST, GRID_LOW_RST};
      cells_q <= GRID_CELLS_RST;
      step_q.delete();
      fail_count <= 0;
    end else begin
      // register writes
      if (psel && penable && pwrite && pready) begin
        case (paddr[4:2])
          REG_CELL_SIZE_X: size_q[0] <= pwdata[30:0];
          REG_CELL_SIZE_Y: size_q[1] <= pwdata[30:0];
          REG_CELL_SIZE_Z: size_q[2] <= pwdata[30:0];
          REG_GRID_LOW_X:  low_q[0]  <= pwdata;
          REG_GRID_LOW_Y:  low_q[1]  <= pwdata;
          REG_GRID_LOW_Z:  low_q[2]  <= pwdata;
          REG_GRID_CELLS:  cells_q   <= pwdata[6:0];
          default: ;
        endcase
      end
      // accepted command word
      if (start && !busy) begin
        org = '{origin_x, origin_y, origin_z};
        dir = '{dir_x, dir_y, dir_z};
        cel = '{cell_x, cell_y, cell_z};
        step_q.insert(step_q.size(), voxel_step(t_now, org, dir, cel));
      end
      // result word
      if (done) begin
        if (step_q.size() == 0) begin
          $error("result word with nothing expected");
          fail_count <= fail_count + 1;
        end else begin
          exp_w = step_q.pop_front();
          if (exp_w != {t_next, next_x, next_y, next_z, leaves_grid}) begin
            fail_count <= fail_count + 1;
            if (exp_w.t != t_next) $error("t_next exp %h got %h", exp_w.t, t_next);
            if (exp_w.nx != next_x) $error("next_x exp %0d got %0d", exp_w.nx, next_x);
            if (exp_w.ny != next_y) $error("next_y exp %0d got %0d", exp_w.ny, next_y);
            if (exp_w.nz != next_z) $error("next_z exp %0d got %0d", exp_w.nz, next_z);
            if (exp_w.leave != leaves_grid)
              $error("leaves_grid exp %0b got %0b", exp_w.leave, leaves_grid);
          end
        end
      end
    end
  end

endmodule

>>> dv/grid_voxel_step_unit_tb.sv
// Testbench top for the voxel step unit: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module grid_voxel_step_unit_tb
  import gvs_pkg::*;
();

  localparam int STALL_LIMIT = 4000;
  // index with no register behind it
  localparam logic [2:0] REG_UNUSED = 3'd7;

  logic        clk, rst;
  logic        start, busy, done, leaves_grid;
  logic [30:0] t_now, t_next;
  logic [31:0] origin_x, origin_y, origin_z, dir_x, dir_y, dir_z;
  logic [5:0]  cell_x, cell_y, cell_z, next_x, next_y, next_z;
  logic        psel, penable, pwrite, pready;
  logic [4:0]  paddr;
  logic [31:0] pwdata, prdata;
  int          fail_count, pending, quiet;
  int          idle_pct;

  grid_voxel_step_unit i_dut (.*);
  grid_voxel_step_unit_checker i_chk (.*);

  always begin
    clk = 1'b0; #10;
    clk = 1'b1; #10;
  end

  // watchdog: cycles without any accepted word or result
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) quiet <= 0;
    else quiet <= quiet + 1;
    if (quiet >= STALL_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  task automatic reg_write(logic [2:0] idx, logic [31:0] val);
    @(negedge clk);
    psel <= 1'b1; pwrite <= 1'b1; paddr <= {idx, 2'b00}; pwdata <= val;
    @(negedge clk);
    penable <= 1'b1;
    @(negedge clk);
    psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
  endtask

  // one command word; start stays high into the next word unless idling
  task automatic send_step(logic [30:0] t, logic [31:0] ox, oy, oz, dx, dy, dz,
                           logic [5:0] cx, cy, cz);
    if ($urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(negedge clk);
      while ($urandom_range(99) < idle_pct) @(negedge clk);
    end
    start <= 1'b1; t_now <= t;
    origin_x <= ox; origin_y <= oy; origin_z <= oz;
    dir_x <= dx; dir_y <= dy; dir_z <= dz;
    cell_x <= cx; cell_y <= cy; cell_z <= cz;
    @(posedge clk);
    while (busy) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic drain();
    start <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (LATENCY + 10) @(posedge clk);
  endtask

  function automatic logic [31:0] rnd_dir();
    case ($urandom_range(5))
      0: return 32'd0;
      1: return $urandom;
      2: return 32'(int'($urandom_range(131072)) - 65536);
      default: return $urandom_range(1) ? 32'($urandom_range(262144))
                                        : -32'($urandom_range(262144));
    endcase
  endfunction

  // random ray that mostly sits consistently inside its cell, default-ish grid
  task automatic rand_steps(int n, int cells);
    logic [5:0] c [3];
    logic [31:0] o [3];
    for (int k = 0; k < n; k++) begin
      for (int a = 0; a < 3; a++) begin
        c[a] = $urandom_range(9) == 0 ? 6'($urandom) : 6'($urandom_range(cells));
        o[a] = $urandom_range(7) == 0 ? $urandom
               : (32'(c[a]) << 16) + 32'($urandom_range(65535));
      end
      send_step($urandom_range(7) == 0 ? 31'($urandom) : 31'($urandom_range(32)),
                o[0], o[1], o[2], rnd_dir(), rnd_dir(), rnd_dir(), c[0], c[1], c[2]);
    end
  endtask

  initial begin
    rst = 1'b1; start = 1'b0; t_now = '0;
    origin_x = '0; origin_y = '0; origin_z = '0;
    dir_x = '0; dir_y = '0; dir_z = '0;
    cell_x = '0; cell_y = '0; cell_z = '0;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    idle_pct = 0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // directed: reset grid, axis steps, ties, zero dir, extremes
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 6'd0, 6'd0, 6'd0);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 0, -32'sd65536, 0, 6'd3, 6'd3, 6'd3);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 0, 0, 32'h10000, 6'd2, 6'd2, 6'd2);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 32'h10000, 32'h10000, 32'h10000,
              6'd1, 6'd1, 6'd1);
    send_step(31'd5, 32'h8000, 32'h8000, 32'h8000, 0, 0, 0, 6'd1, 6'd1, 6'd1);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 6'd7, 6'd0, 6'd0);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, -32'sd65536, 0, 0, 6'd0, 6'd0, 6'd0);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 6'd1, 6'd63, 6'd1);
    send_step(31'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
              32'h7FFF_FFFF, 32'h1, 6'd63, 6'd0, 6'd2);
    send_step(31'd100, 32'h5_0000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 6'd1, 6'd0, 6'd0);
    send_step(31'd0, 32'hFFFF_FFFF, 32'h0, 32'h1, 32'hFFFF_FFFF, 32'h1, 32'h7FFF_FFFF,
              6'd4, 6'd4, 6'd4);
    send_step(31'd1, 32'h8000, 32'h8000, 32'h8000, 32'h1, 32'h1, 32'h1, 6'd2, 6'd2, 6'd2);
    drain();

    // config extremes: huge cells, negative corner, grid over limit, zero cells
    reg_write(REG_CELL_SIZE_X, 32'h7FFF_FFFF);
    reg_write(REG_CELL_SIZE_Y, 32'h1);
    reg_write(REG_CELL_SIZE_Z, 32'h0);
    reg_write(REG_GRID_LOW_X, 32'h8000_0000);
    reg_write(REG_GRID_LOW_Y, 32'h7FFF_FFFF);
    reg_write(REG_GRID_LOW_Z, 32'hFFFF_0000);
    reg_write(REG_GRID_CELLS, 32'd127);
    reg_write(REG_UNUSED, 32'hFFFF_FFFF);
    send_step(31'd0, 32'h0, 32'h0, 32'h0, 32'h10000, 32'h10000, 32'h10000, 6'd63, 6'd5, 6'd0);
    send_step(31'd3, 32'h0, 32'h0, 32'h0, -32'sd1, 32'h10000, 32'h0, 6'd10, 6'd5, 6'd0);
    rand_steps(25, 63);
    drain();
    reg_write(REG_GRID_CELLS, 32'd0);
    send_step(31'd0, 32'h8000, 32'h8000, 32'h8000, 32'h10000, 0, 0, 6'd0, 6'd0, 6'd0);
    drain();
    reg_write(REG_GRID_CELLS, 32'd1);
    rand_steps(20, 1);
    drain();

    // random phases across idling patterns and grid settings
    for (int ph = 0; ph < 4; ph++) begin
      idle_pct = (ph == 0) ? 0 : (ph == 1) ? 88 : (ph == 2) ? 37 : 0;
      reg_write(REG_CELL_SIZE_X, 32'h10000);
      reg_write(REG_CELL_SIZE_Y, ph[0] ? 32'h8000 : 32'h10000);
      reg_write(REG_CELL_SIZE_Z, ph[1] ? $urandom : 32'h10000);
      reg_write(REG_GRID_LOW_X, 32'h0);
      reg_write(REG_GRID_LOW_Y, 32'h0);
      reg_write(REG_GRID_LOW_Z, ph[1] ? $urandom : 32'h0);
      reg_write(REG_GRID_CELLS, (ph == 3) ? 32'd64 : 32'd8 + ph);
      rand_steps(120, (ph == 3) ? 63 : 8 + ph);
      drain();
    end

    if (fail_count == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end

endmodule
